// ===== design/qs_pkg.sv =====
// ----------------------------------------------------------------------------
// qs_pkg - shared types and constants of the quicksort engine
// Data width of one element and the state encoding of the sort sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package qs_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SEED,
        S_POP,
        S_POP_WAIT,
        S_PIVOT,
        S_RCHK,
        S_LCHK,
        S_PLACE,
        S_PUSH_R,
        S_EMIT_RD,
        S_EMIT_WAIT
    } state_t;

endpackage

`default_nettype wire

// ===== design/qs_ram.sv =====
// ----------------------------------------------------------------------------
// qs_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/quicksort_engine.sv =====
// ----------------------------------------------------------------------------
// quicksort_engine - in-place quicksort of a set of signed 32-bit words
// Collects a set, sorts it in an element RAM and streams it out ascending.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall): one word per cycle while the input
//   is not stalled, carrying value and last_in. Up to MAX_ITEMS words are kept;
//   further words are dropped and every result of that set carries overflow = 1.
//   On the word marked last_in the engine stalls its input, sorts the set and
//   then returns one result word per stored element (result_valid /
//   result_stall), ascending, last_out on the final one.
//   Sorting is set by the single read port of the element RAM: each partition
//   pass touches its range at one element per cycle, plus range overhead in
//   the stack pop, pivot read, pivot placement and right-push states.
//   Emission reads one result at a time from the element RAM and registers it
//   into the output register. A stalled result holds in the output register;
//   the engine waits for it. Once the final result sits in the output register
//   the input opens again. Reset empties the set and clears the state, overflow
//   flag, stack pointer and result valid; RAM contents persist.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_engine #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire logic signed [qs_pkg::DATA_W-1:0] value,
    input  wire logic                             last_in,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic signed      [qs_pkg::DATA_W-1:0] sorted_value,
    output logic                                  last_out,
    output logic                                  overflow
);

    import qs_pkg::*;

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int W1    = IDX_W + 1;
    localparam int SE_W  = 2 * IDX_W;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [IDX_W-1:0]  sp_reg, sp_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  l_reg, l_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [DATA_W-1:0] pivot_reg, pivot_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;
    logic              out_valid_reg, out_valid_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;
    logic              stk_we;
    logic [IDX_W-1:0]  stk_waddr, stk_raddr;
    logic [SE_W-1:0]   stk_wdata, stk_rdata;

    logic item_acc, result_acc;
    logic l_lt_r, l_ne_r, gt_pivot, lt_pivot, last_k, push_left, push_right, out_free;

    qs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_elem_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    qs_ram #(.WIDTH(SE_W), .DEPTH(MAX_ITEMS)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign item_stall   = (state_reg != S_LOAD);
    assign item_acc     = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result_acc   = out_valid_reg && !result_stall;
    assign sorted_value = $signed(out_value_reg);
    assign last_out     = out_last_reg;
    assign overflow     = out_ovf_reg;

    assign l_lt_r     = (l_reg < r_reg);
    assign l_ne_r     = (l_reg != r_reg);
    assign gt_pivot   = ($signed(mem_rdata) > $signed(pivot_reg));
    assign lt_pivot   = ($signed(mem_rdata) < $signed(pivot_reg));
    assign last_k     = ((W1'(k_reg) + W1'(1)) == W1'(count_reg));
    // subranges of one element are already in place: push only two or more
    assign push_left  = (W1'(l_reg) > (W1'(lo_reg) + W1'(1)));
    assign push_right = ((W1'(l_reg) + W1'(1)) < W1'(hi_reg));
    assign out_free   = !out_valid_reg || !result_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (item_acc && last_in)
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:      state_next = (count_reg >= CNT_W'(2)) ? S_POP : S_EMIT_RD;
            S_POP:       state_next = (sp_reg == '0) ? S_EMIT_RD : S_POP_WAIT;
            S_POP_WAIT:  state_next = S_PIVOT;
            S_PIVOT:     state_next = l_lt_r ? S_RCHK : S_PLACE;
            S_RCHK:
            begin
                if (gt_pivot && l_lt_r)
                begin
                    state_next = S_RCHK;
                end
                else if (l_ne_r)
                begin
                    state_next = S_LCHK;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_LCHK:
            begin
                if (lt_pivot && l_lt_r)
                begin
                    state_next = S_LCHK;
                end
                else if (l_ne_r && (W1'(l_reg) + W1'(1) < W1'(r_reg)))
                begin
                    state_next = S_RCHK;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:     state_next = S_PUSH_R;
            S_PUSH_R:    state_next = S_POP;
            S_EMIT_RD:
            begin
                if (out_free)
                begin
                    state_next = S_EMIT_WAIT;
                end
            end
            S_EMIT_WAIT: state_next = last_k ? S_LOAD : S_EMIT_RD;
            default:     state_next = S_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        sp_next        = sp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        pivot_next     = pivot_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = result_acc ? 1'b0 : out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = l_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = '0;
        stk_we         = 1'b0;
        stk_waddr      = sp_reg;
        stk_wdata      = {lo_reg, IDX_W'(l_reg - IDX_W'(1))};
        stk_raddr      = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (item_acc)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IDX_W-1:0];
                        mem_wdata  = value;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            S_SEED:
            begin
                k_next = '0;
                if (count_reg >= CNT_W'(2))
                begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = {IDX_W'(0), IDX_W'(count_reg - CNT_W'(1))};
                    sp_next   = IDX_W'(1);
                end
            end
            S_POP:
            begin
                if (sp_reg != '0)
                begin
                    stk_raddr = sp_reg - IDX_W'(1);
                    sp_next   = sp_reg - IDX_W'(1);
                end
            end
            S_POP_WAIT:
            begin
                lo_next   = stk_rdata[SE_W-1:IDX_W];
                hi_next   = stk_rdata[IDX_W-1:0];
                l_next    = stk_rdata[SE_W-1:IDX_W];
                r_next    = stk_rdata[IDX_W-1:0];
                mem_raddr = stk_rdata[SE_W-1:IDX_W];
            end
            S_PIVOT:
            begin
                pivot_next = mem_rdata;
                mem_raddr  = r_reg;
            end
            S_RCHK:
            begin
                if (gt_pivot && l_lt_r)
                begin
                    r_next    = r_reg - IDX_W'(1);
                    mem_raddr = r_reg - IDX_W'(1);
                end
                else if (l_ne_r)
                begin
                    // fill the hole on the left, move on to the left scan
                    mem_we    = 1'b1;
                    mem_waddr = l_reg;
                    l_next    = l_reg + IDX_W'(1);
                    mem_raddr = l_reg + IDX_W'(1);
                end
            end
            S_LCHK:
            begin
                if (lt_pivot && l_lt_r)
                begin
                    l_next    = l_reg + IDX_W'(1);
                    mem_raddr = l_reg + IDX_W'(1);
                end
                else if (l_ne_r)
                begin
                    // fill the hole on the right, resume the right scan while the ends have not met
                    mem_we    = 1'b1;
                    mem_waddr = r_reg;
                    r_next    = r_reg - IDX_W'(1);
                    mem_raddr = r_reg - IDX_W'(1);
                end
            end
            S_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = l_reg;
                mem_wdata = pivot_reg;
                if (push_left)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {lo_reg, IDX_W'(l_reg - IDX_W'(1))};
                    sp_next   = sp_reg + IDX_W'(1);
                end
            end
            S_PUSH_R:
            begin
                if (push_right)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {IDX_W'(l_reg + IDX_W'(1)), hi_reg};
                    sp_next   = sp_reg + IDX_W'(1);
                end
            end
            S_EMIT_RD:
            begin
                mem_raddr = k_reg;
            end
            S_EMIT_WAIT:
            begin
                out_value_next = mem_rdata;
                out_last_next  = last_k;
                out_ovf_next   = dropped_reg;
                out_valid_next = 1'b1;
                if (last_k)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    sp_next      = '0;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        k_reg         <= k_next;
        pivot_reg     <= pivot_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

`default_nettype wire

// ===== design/qs_checker.sv =====
// ----------------------------------------------------------------------------
// qs_checker - port-level checks for the quicksort engine
// Watches both channels and the ordering of load, sort and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             item_valid,
    input wire logic                             item_stall,
    input wire logic                             last_in,
    input wire logic                             result_valid,
    input wire logic                             result_stall,
    input wire logic signed [qs_pkg::DATA_W-1:0] sorted_value,
    input wire logic                             last_out,
    input wire logic                             overflow
);

    // hold a stalled result word
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(sorted_value)
            && $stable(last_out) && $stable(overflow))
        else $error("stalled result word changed");

    // close the input once a set is complete
    a_close_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && last_in |=> item_stall)
        else $error("input open after last word of set");

    // keep the input closed while results of a set remain
    a_closed_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last_out |=> item_stall)
        else $error("input open while results remain");

    // advance loading one word per cycle
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !last_in |=> !item_stall)
        else $error("input stalled during loading");

endmodule

bind quicksort_engine qs_checker u_qs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .last_in      (last_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow)
);

`default_nettype wire

// ===== tb/quicksort_engine_test.sv =====
// ----------------------------------------------------------------------------
// quicksort_engine_test - self-checking testbench of the quicksort engine
// Streams data sets of signed words into the engine and compares every
// sorted result word, with its last and overflow marks, against an
// in-bench prediction. Sender gaps and receiver stalls are randomised.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quicksort_engine_test;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 300000;

    typedef logic signed [qs_pkg::DATA_W-1:0] word_t;
    typedef word_t word_queue_t[$];

    typedef struct {
        word_t sorted_value;
        logic  last_out;
        logic  overflow;
    } sorted_word_t;

    typedef enum int {
        FILL_FULL_RANGE,
        FILL_NARROW,
        FILL_EXTREMES
    } fill_t;

    localparam word_t WORD_MIN = {1'b1, {(qs_pkg::DATA_W-1){1'b0}}};
    localparam word_t WORD_MAX = {1'b0, {(qs_pkg::DATA_W-1){1'b1}}};

    logic  clk          = 1'b0;
    logic  rst_n        = 1'b0;
    logic  item_valid   = 1'b0;
    word_t value        = '0;
    logic  last_in      = 1'b0;
    logic  result_stall = 1'b0;
    logic  item_stall;
    logic  result_valid;
    word_t sorted_value;
    logic  last_out;
    logic  overflow;

    // predictor state: the set collected so far and the expected result words
    word_t        held_words[$];
    logic         held_dropped = 1'b0;
    sorted_word_t pending_sorted[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int failures           = 0;
    int words_sent         = 0;
    int sets_sent          = 0;
    int overflow_sets      = 0;
    int results_checked    = 0;
    int cycle_count        = 0;

    quicksort_engine #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .value(value),
        .last_in(last_in),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .sorted_value(sorted_value),
        .last_out(last_out),
        .overflow(overflow)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic word_queue_t ascending_order(input word_queue_t words);
        word_queue_t ordered;
        int pos;
        foreach (words[i])
        begin
            pos = 0;
            while (pos < ordered.size() && ordered[pos] <= words[i])
                pos++;
            ordered.insert(pos, words[i]);
        end
        return ordered;
    endfunction

    // Store the word, or drop it once the set is full; on the last word
    // queue the whole set in ascending order and start a fresh set.
    function automatic void absorb_word(input word_t v, input logic is_last);
        word_queue_t ordered;
        sorted_word_t expected_word;
        if (held_words.size() < CAPACITY)
            held_words.push_back(v);
        else
            held_dropped = 1'b1;
        if (is_last)
        begin
            ordered = ascending_order(held_words);
            foreach (ordered[i])
            begin
                expected_word.sorted_value = ordered[i];
                expected_word.last_out     = (i == ordered.size() - 1);
                expected_word.overflow     = held_dropped;
                pending_sorted.push_back(expected_word);
            end
            if (held_dropped)
                overflow_sets++;
            held_words.delete();
            held_dropped = 1'b0;
        end
    endfunction

    task automatic check_result();
        sorted_word_t expected_word;
        if (pending_sorted.size() == 0)
        begin
            $error("unexpected result word: sorted_value %0d", sorted_value);
            failures++;
        end
        else
        begin
            expected_word = pending_sorted.pop_front();
            if (sorted_value !== expected_word.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d",
                       expected_word.sorted_value, sorted_value);
                failures++;
            end
            if (last_out !== expected_word.last_out)
            begin
                $error("last_out: expected %0b, got %0b", expected_word.last_out, last_out);
                failures++;
            end
            if (overflow !== expected_word.overflow)
            begin
                $error("overflow: expected %0b, got %0b", expected_word.overflow, overflow);
                failures++;
            end
        end
        results_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result();
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Called at a rising edge; returns at the edge that takes the word.
    task automatic send_word(input word_t v, input logic is_last);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        item_valid <= 1'b1;
        value      <= v;
        last_in    <= is_last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        absorb_word(v, is_last);
        words_sent++;
    endtask

    task automatic send_set(input word_queue_t words);
        foreach (words[i])
            send_word(words[i], i == words.size() - 1);
        sets_sent++;
    endtask

    function automatic word_t random_word(input fill_t fill);
        word_t w;
        case (fill)
            FILL_NARROW:
                w = word_t'($urandom_range(6)) - 3;
            FILL_EXTREMES:
                case ($urandom_range(3))
                    0:       w = WORD_MIN;
                    1:       w = WORD_MAX;
                    2:       w = '0;
                    default: w = '1;
                endcase
            default:
                w = word_t'($urandom);
        endcase
        return w;
    endfunction

    function automatic word_queue_t random_set(input int size, input fill_t fill);
        word_queue_t words;
        repeat (size)
            words.push_back(random_word(fill));
        return words;
    endfunction

    task automatic test_edge_values();
        send_set('{WORD_MIN});
        send_set('{WORD_MAX, WORD_MIN});
        send_set('{word_t'(0), word_t'(-1), WORD_MIN, WORD_MAX,
                   word_t'(32'h5555_5555), word_t'(32'hAAAA_AAAA), word_t'(1), word_t'(-2)});
        send_set('{word_t'(7), word_t'(7), word_t'(7), word_t'(7)});
        send_set('{word_t'(1), word_t'(2), word_t'(3)});
        send_set('{word_t'(3), word_t'(2), word_t'(1)});
    endtask

    // Fill the store and run past its end so the last words are dropped,
    // then check that the overflow mark clears on the following set.
    task automatic test_capacity();
        send_set(random_set(CAPACITY + 3, FILL_FULL_RANGE));
        send_set(random_set(2, FILL_NARROW));
    endtask

    // Presorted and reversed data drive the first-element pivot to its worst case; a set of extreme values follows.
    task automatic test_ordered_runs();
        word_queue_t ordered;
        word_queue_t reversed;
        ordered = ascending_order(random_set($urandom_range(8, 16), FILL_FULL_RANGE));
        send_set(ordered);
        ordered = ascending_order(random_set($urandom_range(8, 16), FILL_FULL_RANGE));
        reversed.delete();
        foreach (ordered[i])
            reversed.push_front(ordered[i]);
        send_set(reversed);
        send_set(random_set($urandom_range(8, 16), FILL_EXTREMES));
    endtask

    task automatic test_random_sets(input int word_target);
        int goal;
        int pick;
        int size;
        fill_t fill;
        goal = words_sent + word_target;
        while (words_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                size = $urandom_range(1, 10);
            else if (pick < 95)
                size = $urandom_range(11, 24);
            else
                size = $urandom_range(25, 40);
            pick = $urandom_range(99);
            fill = (pick < 70) ? FILL_FULL_RANGE : (pick < 90) ? FILL_NARROW : FILL_EXTREMES;
            send_set(random_set(size, fill));
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct    = 12;
        receiver_stall_pct = 49;
        test_edge_values();
        test_capacity();

        sender_idle_pct    = 49;
        receiver_stall_pct = 12;
        test_ordered_runs();
        test_random_sets(15);

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_random_sets(15);

        item_valid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        // hold a little longer to catch any stray result word
        repeat (16)
            @(posedge clk);

        $display("Sorted %0d sets from %0d input words, %0d of them overflowed.",
                 sets_sent, words_sent, overflow_sets);
        $display("Checked %0d result words across idle, stall and back-to-back phases.",
                 results_checked);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== quicksort_engine.f =====
design/qs_pkg.sv
design/qs_ram.sv
design/quicksort_engine.sv
design/qs_checker.sv
tb/quicksort_engine_test.sv
